FILE: rtl/crc8fr_pkg.sv
// crc8fr_pkg: shared constants, types and the crc-8 byte update for the frame receiver
// used by crc8fr_ctrl, crc8fr_dp and crc8_frame_receiver_top; no dependencies

package crc8fr_pkg;

  localparam int MaxPayload = 60;
  localparam int AddrW      = $clog2(MaxPayload + 1);

  localparam logic [7:0] HDR1_BYTE = 8'hAA;
  localparam logic [7:0] HDR2_BYTE = 8'h55;
  localparam logic [7:0] TL1_BYTE  = 8'h0D;
  localparam logic [7:0] TL2_BYTE  = 8'h0A;
  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] CRC_MSB   = 8'h80;
  localparam logic [7:0] MAX_LEN   = 8'(MaxPayload);

  typedef enum logic [1:0] {
    EV_DATA    = 2'd0,
    EV_EMPTY   = 2'd1,
    EV_LEN_ERR = 2'd2,
    EV_CRC_ERR = 2'd3
  } event_kind_t;

  // controller -> datapath
  typedef struct packed {
    logic start;        // first header byte seen: clear crc and count
    logic take_len;
    logic take_cmd;
    logic take_data;
    logic clear_count;  // second tail byte transfer
    logic emit_len_err;
    logic emit_crc_err;
    logic emit_empty;
    logic rd_first;     // read payload entry 0
    logic emit_load;    // move buffered byte to output, read next
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hdr1_match;
    logic hdr2_match;
    logic len_ok;
    logic len_zero;
    logic data_done;
    logic crc_match;
    logic tl1_match;
    logic tl2_match;
    logic out_free;
    logic emit_last;
  } dp_status_t;

  // msb-first crc-8 update of one byte, no final xor
  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] v;
    v = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((v & CRC_MSB) != 8'h00) begin
        v = (v << 1) ^ CRC_POLY;
      end else begin
        v = v << 1;
      end
    end
    return v;
  endfunction

endpackage

FILE: rtl/crc8fr_ctrl.sv
// crc8fr_ctrl: frame hunt and payload burst state machine
// depends on crc8fr_pkg; drives the datapath crc8fr_dp through dp_cmd_t

module crc8fr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  crc8fr_pkg::dp_status_t st,
  output crc8fr_pkg::dp_cmd_t    cmd
);

  typedef enum logic [9:0] {
    ST_HDR1  = 10'b0000000001,
    ST_HDR2  = 10'b0000000010,
    ST_LEN   = 10'b0000000100,
    ST_CMD   = 10'b0000001000,
    ST_DATA  = 10'b0000010000,
    ST_CRC   = 10'b0000100000,
    ST_TL1   = 10'b0001000000,
    ST_TL2   = 10'b0010000000,
    ST_PRIME = 10'b0100000000,
    ST_EMIT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   parsing;
  logic   acc;

  assign parsing  = (state_r != ST_PRIME) && (state_r != ST_EMIT);
  assign in_ready = parsing && st.out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_HDR1: begin
        if (acc && st.hdr1_match) begin
          cmd.start = 1'b1;
          state_nxt = ST_HDR2;
        end
      end
      ST_HDR2: begin
        if (acc) begin
          state_nxt = st.hdr2_match ? ST_LEN : ST_HDR1;
        end
      end
      ST_LEN: begin
        if (acc) begin
          cmd.take_len = 1'b1;
          if (st.len_ok) begin
            state_nxt = ST_CMD;
          end else begin
            cmd.emit_len_err = 1'b1;
            state_nxt        = ST_HDR1;
          end
        end
      end
      ST_CMD: begin
        if (acc) begin
          cmd.take_cmd = 1'b1;
          state_nxt    = st.len_zero ? ST_CRC : ST_DATA;
        end
      end
      ST_DATA: begin
        if (acc) begin
          cmd.take_data = 1'b1;
          if (st.data_done) begin
            state_nxt = ST_CRC;
          end
        end
      end
      ST_CRC: begin
        if (acc) begin
          if (st.crc_match) begin
            state_nxt = ST_TL1;
          end else begin
            cmd.emit_crc_err = 1'b1;
            state_nxt        = ST_HDR1;
          end
        end
      end
      ST_TL1: begin
        if (acc) begin
          state_nxt = st.tl1_match ? ST_TL2 : ST_HDR1;
        end
      end
      ST_TL2: begin
        if (acc) begin
          cmd.clear_count = 1'b1;
          state_nxt       = ST_HDR1;
          if (st.tl2_match) begin
            if (st.len_zero) begin
              cmd.emit_empty = 1'b1;
            end else begin
              state_nxt = ST_PRIME;
            end
          end
        end
      end
      ST_PRIME: begin
        cmd.rd_first = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit_load = 1'b1;
          if (st.emit_last) begin
            state_nxt = ST_HDR1;
          end
        end
      end
      default: begin
        state_nxt = ST_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HDR1;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/crc8fr_dp.sv
// crc8fr_dp: frame fields, running crc, payload buffer and result register
// depends on crc8fr_pkg; commanded by crc8fr_ctrl

module crc8fr_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             rx_byte,
  input  crc8fr_pkg::dp_cmd_t     cmd,
  output crc8fr_pkg::dp_status_t  st,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_event_kind,
  output logic [7:0]             out_command_code,
  output logic [7:0]             out_payload_byte,
  output logic [7:0]             out_payload_length,
  output logic                   out_last_of_frame
);

  localparam int AW = crc8fr_pkg::AddrW;

  logic [7:0]    frame_length_r;
  logic [7:0]    frame_command_r;
  logic [7:0]    crc_r;
  logic [AW-1:0] bytes_seen_r;
  logic [AW-1:0] rd_idx_r;
  logic [7:0]    rd_data_r;
  logic [7:0]    mem [crc8fr_pkg::MaxPayload];

  logic          out_valid_r;
  logic [1:0]    kind_r;
  logic [7:0]    cmd_code_r;
  logic [7:0]    pbyte_r;
  logic [7:0]    plen_r;
  logic          last_r;

  logic [7:0]    crc_in;
  logic [7:0]    crc_nxt;
  logic [7:0]    seen_inc;
  logic          emit_any;

  assign crc_in   = cmd.take_len ? 8'h00 : crc_r;
  assign crc_nxt  = crc8fr_pkg::crc8_byte(crc_in, rx_byte);
  assign seen_inc = 8'(bytes_seen_r) + 8'd1;

  assign st.hdr1_match = (rx_byte == crc8fr_pkg::HDR1_BYTE);
  assign st.hdr2_match = (rx_byte == crc8fr_pkg::HDR2_BYTE);
  assign st.len_ok     = (rx_byte <= crc8fr_pkg::MAX_LEN);
  assign st.len_zero   = (frame_length_r == 8'h00);
  assign st.data_done  = (seen_inc >= frame_length_r);
  assign st.crc_match  = (rx_byte == crc_r);
  assign st.tl1_match  = (rx_byte == crc8fr_pkg::TL1_BYTE);
  assign st.tl2_match  = (rx_byte == crc8fr_pkg::TL2_BYTE);
  assign st.out_free   = !out_valid_r || out_ready;
  assign st.emit_last  = (8'(rd_idx_r) == frame_length_r);

  assign emit_any = cmd.emit_len_err || cmd.emit_crc_err || cmd.emit_empty || cmd.emit_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r  <= 8'h00;
      frame_command_r <= 8'h00;
      crc_r           <= 8'h00;
      bytes_seen_r    <= '0;
      rd_idx_r        <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cmd.start) begin
        crc_r        <= 8'h00;
        bytes_seen_r <= '0;
      end
      if (cmd.take_len) begin
        frame_length_r <= rx_byte;
      end
      if (cmd.take_cmd) begin
        frame_command_r <= rx_byte;
      end
      if (cmd.take_len || cmd.take_cmd || cmd.take_data) begin
        crc_r <= crc_nxt;
      end
      if (cmd.take_data) begin
        bytes_seen_r <= AW'(seen_inc);
      end
      if (cmd.clear_count) begin
        bytes_seen_r <= '0;
      end
      if (cmd.rd_first) begin
        rd_idx_r <= AW'(1);
      end else if (cmd.emit_load) begin
        rd_idx_r <= rd_idx_r + AW'(1);
      end
      if (emit_any) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload buffer, read data registered
  always_ff @(posedge clk) begin
    if (cmd.take_data && (bytes_seen_r < AW'(crc8fr_pkg::MaxPayload))) begin
      mem[bytes_seen_r] <= rx_byte;
    end
    if (cmd.rd_first) begin
      rd_data_r <= mem[0];
    end else if (cmd.emit_load && (8'(rd_idx_r) < frame_length_r)) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit_len_err) begin
      kind_r     <= crc8fr_pkg::EV_LEN_ERR;
      cmd_code_r <= 8'h00;
      pbyte_r    <= rx_byte;
      plen_r     <= rx_byte;
      last_r     <= 1'b1;
    end else if (cmd.emit_crc_err) begin
      kind_r     <= crc8fr_pkg::EV_CRC_ERR;
      cmd_code_r <= frame_command_r;
      pbyte_r    <= rx_byte;
      plen_r     <= frame_length_r;
      last_r     <= 1'b1;
    end else if (cmd.emit_empty) begin
      kind_r     <= crc8fr_pkg::EV_EMPTY;
      cmd_code_r <= frame_command_r;
      pbyte_r    <= 8'h00;
      plen_r     <= 8'h00;
      last_r     <= 1'b1;
    end else if (cmd.emit_load) begin
      kind_r     <= crc8fr_pkg::EV_DATA;
      cmd_code_r <= frame_command_r;
      pbyte_r    <= rd_data_r;
      plen_r     <= frame_length_r;
      last_r     <= st.emit_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = kind_r;
  assign out_command_code   = cmd_code_r;
  assign out_payload_byte   = pbyte_r;
  assign out_payload_length = plen_r;
  assign out_last_of_frame  = last_r;

endmodule

FILE: rtl/crc8_frame_receiver_top.sv
// crc8_frame_receiver_top: byte-stream deframer with crc-8 check, top level
// depends on crc8fr_pkg, crc8fr_ctrl and crc8fr_dp

// Takes one received byte per transfer and hunts for frames AA 55 LEN CMD PAYLOAD CRC 0D 0A,
// crc-8 poly 0x07, init 0, over LEN, CMD and payload. While parsing, a byte is taken every
// cycle as long as the result register is free or being drained. After a good tail a frame of
// N payload bytes is sent as N results: a prime state reads the first payload buffer entry, then
// the emit state gives one result per cycle while the result register is free or being drained;
// no byte is taken during that burst. Empty frames, length errors and crc errors give one result
// on the byte's own transfer. A result that is not taken holds off the next byte.

module crc8_frame_receiver_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_kind,
  output logic [7:0] out_command_code,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_payload_length,
  output logic       out_last_of_frame
);

  crc8fr_pkg::dp_cmd_t    cmd;
  crc8fr_pkg::dp_status_t st;

  crc8fr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  crc8fr_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .rx_byte            (in_rx_byte),
    .cmd                (cmd),
    .st                 (st),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .out_command_code   (out_command_code),
    .out_payload_byte   (out_payload_byte),
    .out_payload_length (out_payload_length),
    .out_last_of_frame  (out_last_of_frame)
  );

endmodule
